// ===== hdl/kalman_pid_attitude_axis_unit_assert.svh =====
// Assertion macros for the attitude axis unit.
`ifndef KALMAN_PID_ATTITUDE_AXIS_UNIT_ASSERT_SVH
`define KALMAN_PID_ATTITUDE_AXIS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define KPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KPA_ASSERT_IMP(lbl, ante, cons, msg)
`define KPA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/kpa_pkg.sv =====
package kpa_pkg;
    localparam int AXES_DEF   = 2;
    localparam int MUL_AW     = 40;
    localparam int MUL_BW     = 24;
    localparam int DIV_NW     = 64;
    localparam int DIV_DW     = 34;

    localparam logic [13:0] PRED_DIV   = 14'd16375;
    localparam logic [12:0] PRED_HALF  = 13'd8187;
    localparam logic [12:0] PROC_NOISE = 13'd4194;
    localparam logic [19:0] MEAS_NOISE = 20'd589824;
    localparam logic [31:0] UNC_RESET  = 32'd262144;
    localparam logic [25:0] INT_DIV    = 26'd65536000;
    localparam logic [24:0] INT_HALF   = 25'd32768000;
    localparam logic [9:0]  RATE_SCALE = 10'd1000;
    localparam logic [23:0] KP_RESET   = 24'd196608;
    localparam logic [23:0] KI_RESET   = 24'd655;
    localparam logic [23:0] KD_RESET   = 24'd98304;

    typedef enum logic [2:0] {
        CFG_ROLL_OFS  = 3'd0,
        CFG_PITCH_OFS = 3'd1,
        CFG_ROLL_TGT  = 3'd2,
        CFG_PITCH_TGT = 3'd3,
        CFG_KP        = 3'd4,
        CFG_KI        = 3'd5,
        CFG_KD        = 3'd6
    } t_cfg_idx;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
        logic signed [39:0] r;
        if (v > 64'sd549755813887) r = 40'sh7FFFFFFFFF;
        else if (v < -64'sd549755813888) r = 40'sh8000000000;
        else r = v[39:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) r = 16'sh7FFF;
        else if (v < -64'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        logic [63:0] r;
        r = v[63] ? 64'(-v) : 64'(v);
        return r;
    endfunction

    function automatic logic signed [63:0] apply_sign(input logic neg, input logic [63:0] m);
        logic signed [63:0] r;
        r = neg ? -$signed(m) : $signed(m);
        return r;
    endfunction
endpackage

// ===== hdl/kpa_mul.sv =====
module kpa_mul import kpa_pkg::*; #(
    parameter int AW = MUL_AW,
    parameter int BW = MUL_BW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic             o_done,
    output logic [AW+BW-1:0] o_prod
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_a, r_acc;
    logic [BW-1:0] r_b;

    // shift-add, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= PW'(i_a);
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= CW'(BW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) r_acc <= r_acc + r_a;
                r_a   <= {r_a[PW-2:0], 1'b0};
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ===== hdl/kpa_div.sv =====
module kpa_div import kpa_pkg::*; #(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_n;
    logic [DW-1:0] r_rem, r_d;
    logic [DW:0]   w_trial;

    assign w_trial = {r_rem, r_n[NW-1]};

    // restoring division, one quotient bit per cycle shifted into r_n
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n    <= i_num;
                r_d    <= i_den;
                r_rem  <= '0;
                r_cnt  <= CW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_trial >= {1'b0, r_d}) begin
                    r_rem <= DW'(w_trial - {1'b0, r_d});
                    r_n   <= {r_n[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial[DW-1:0];
                    r_n   <= {r_n[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_n;
endmodule

// ===== hdl/kalman_pid_attitude_axis_unit.sv =====
// One-axis attitude stage: gyro-driven 1D Kalman filter followed by a PID servo loop, one
// result word per input word. Work runs through one shared shift-add multiplier (one bit per
// cycle) and one shared restoring divider, seven products and three or four quotients in
// turn; the derivative quotient is skipped when elapsed time is zero. A stalled output holds
// the next result in the done state. One item is in flight at a time; a finished result sits
// in the output register while the next word is accepted.
`include "kalman_pid_attitude_axis_unit_assert.svh"
module kalman_pid_attitude_axis_unit import kpa_pkg::*; #(
    parameter int AXES = AXES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // gyro_raw, accel_angle, elapsed_ms
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // servo_position, filtered_angle
    output logic        m_axis_tuser,   // axis_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_PRED, S_PRED_W, S_KG_W, S_KM_W, S_UP_W, S_IN_W, S_DF_W,
        S_DD_W, S_PM_W, S_IM_W, S_ID_W, S_DM_W, S_DONE
    } t_state;

    t_state r_state;

    logic signed [15:0] r_roll_ofs, r_pitch_ofs, r_roll_tgt, r_pitch_tgt;
    logic [23:0]        r_kp, r_ki, r_kd;

    logic signed [31:0] r_ang   [AXES];
    logic [31:0]        r_unc   [AXES];
    logic signed [39:0] r_integ [AXES];
    logic signed [31:0] r_prev  [AXES];

    logic               r_kind;
    logic [AW-1:0]      r_ax;
    logic signed [15:0] r_gyro, r_meas;
    logic [15:0]        r_dt;
    logic               r_neg, r_eneg;
    logic signed [63:0] r_est, r_u;
    logic [31:0]        r_p;
    logic [16:0]        r_k;
    logic signed [31:0] r_err, r_rate;
    logic signed [39:0] r_int;

    logic               r_mul_start, r_div_start;
    logic [MUL_AW-1:0]  r_mul_a;
    logic [MUL_BW-1:0]  r_mul_b;
    logic [DIV_NW-1:0]  r_div_n;
    logic [DIV_DW-1:0]  r_div_d;
    logic               w_mul_done, w_div_done;
    logic [MUL_AW+MUL_BW-1:0] w_prod;
    logic [DIV_NW-1:0]  w_quo;

    logic               r_out_valid, r_out_axis;
    logic [7:0]         r_out_servo;
    logic signed [15:0] r_out_filt;

    logic               w_in_acc;
    logic [AW-1:0]      w_ax;
    logic signed [15:0] w_ofs, w_tgt;
    logic signed [16:0] w_r;
    logic [16:0]        w_rmag;
    logic [32:0]        w_psum;
    logic [31:0]        w_ppred;
    logic signed [63:0] w_kdiff, w_err64, w_dd, w_pos;
    logic signed [31:0] w_err;
    logic [63:0]        w_prnd;
    logic [7:0]         w_servo;

    kpa_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mul_start),
        .i_a(r_mul_a), .i_b(r_mul_b), .o_done(w_mul_done), .o_prod(w_prod)
    );

    kpa_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_num(r_div_n), .i_den(r_div_d), .o_done(w_div_done), .o_quo(w_quo)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (AXES > 1) w_ax = AW'(s_axis_tuser);
        else          w_ax = '0;
        w_ofs   = r_kind ? r_pitch_ofs : r_roll_ofs;
        w_tgt   = r_kind ? r_pitch_tgt : r_roll_tgt;
        w_r     = $signed({r_gyro[15], r_gyro}) - $signed({w_ofs[15], w_ofs});
        w_rmag  = w_r[16] ? 17'(-w_r) : 17'(w_r);
        w_psum  = {1'b0, r_unc[r_ax]} + 33'(PROC_NOISE);
        w_ppred = w_psum[32] ? 32'hFFFFFFFF : w_psum[31:0];
        w_kdiff = 64'(r_meas) - r_est;
        w_err64 = 64'(w_tgt) - r_est;
        w_err   = sat32(w_err64);
        w_dd    = 64'(r_err) - 64'(r_prev[r_ax]);
        w_prnd  = (w_prod + 64'd32768) >> 16;
        w_pos   = 64'sd23040 + r_u;
        if (w_pos <= 64'sd0)          w_servo = 8'd0;
        else if (w_pos >= 64'sd46080) w_servo = 8'd180;
        else                          w_servo = w_pos[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_ofs  <= '0;
            r_pitch_ofs <= '0;
            r_roll_tgt  <= '0;
            r_pitch_tgt <= '0;
            r_kp        <= KP_RESET;
            r_ki        <= KI_RESET;
            r_kd        <= KD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROLL_OFS:  r_roll_ofs  <= i_cfg_data[15:0];
                CFG_PITCH_OFS: r_pitch_ofs <= i_cfg_data[15:0];
                CFG_ROLL_TGT:  r_roll_tgt  <= i_cfg_data[15:0];
                CFG_PITCH_TGT: r_pitch_tgt <= i_cfg_data[15:0];
                CFG_KP:        r_kp        <= i_cfg_data;
                CFG_KI:        r_ki        <= i_cfg_data;
                CFG_KD:        r_kd        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_ang[i]   <= '0;
                r_unc[i]   <= UNC_RESET;
                r_integ[i] <= '0;
                r_prev[i]  <= '0;
            end
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            // in S_DONE the load below decides the valid flag
            if (m_axis_tvalid && m_axis_tready && r_state != S_DONE) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_kind  <= s_axis_tuser;
                        r_ax    <= w_ax;
                        r_gyro  <= s_axis_tdata[15:0];
                        r_meas  <= s_axis_tdata[31:16];
                        r_dt    <= s_axis_tdata[47:32];
                        r_state <= S_PRED;
                    end
                end
                S_PRED: begin
                    r_neg       <= w_r[16];
                    r_div_n     <= (64'(w_rmag) << 8) + 64'(PRED_HALF);
                    r_div_d     <= DIV_DW'(PRED_DIV);
                    r_div_start <= 1'b1;
                    r_est       <= 64'(r_ang[r_ax]);
                    r_state     <= S_PRED_W;
                end
                S_PRED_W: begin
                    if (w_div_done) begin
                        r_est       <= r_est + apply_sign(r_neg, w_quo);
                        r_p         <= w_ppred;
                        r_div_n     <= {16'b0, w_ppred, 16'b0};
                        r_div_d     <= DIV_DW'(w_ppred) + DIV_DW'(MEAS_NOISE);
                        r_div_start <= 1'b1;
                        r_state     <= S_KG_W;
                    end
                end
                S_KG_W: begin
                    if (w_div_done) begin
                        r_k         <= w_quo[16:0];
                        r_neg       <= w_kdiff[63];
                        r_mul_a     <= MUL_AW'(mag64(w_kdiff));
                        r_mul_b     <= MUL_BW'(w_quo[16:0]);
                        r_mul_start <= 1'b1;
                        r_state     <= S_KM_W;
                    end
                end
                S_KM_W: begin
                    if (w_mul_done) begin
                        r_est       <= 64'(sat32(r_est + apply_sign(r_neg, w_prnd)));
                        r_mul_a     <= MUL_AW'(r_p);
                        r_mul_b     <= MUL_BW'(17'h10000 - r_k);
                        r_mul_start <= 1'b1;
                        r_state     <= S_UP_W;
                    end
                end
                S_UP_W: begin
                    if (w_mul_done) begin
                        r_unc[r_ax] <= w_prod[47:16];
                        r_ang[r_ax] <= r_est[31:0];
                        r_err       <= w_err;
                        r_eneg      <= w_err[31];
                        r_mul_a     <= MUL_AW'(mag64(64'(w_err)));
                        r_mul_b     <= MUL_BW'(r_dt);
                        r_mul_start <= 1'b1;
                        r_state     <= S_IN_W;
                    end
                end
                S_IN_W: begin
                    if (w_mul_done) begin
                        r_int         <= sat40(64'(r_integ[r_ax]) + apply_sign(r_eneg, w_prod));
                        r_integ[r_ax] <= sat40(64'(r_integ[r_ax]) + apply_sign(r_eneg, w_prod));
                        r_neg         <= w_dd[63];
                        r_mul_a       <= MUL_AW'(mag64(w_dd));
                        r_mul_b       <= MUL_BW'(RATE_SCALE);
                        r_mul_start   <= 1'b1;
                        r_state       <= S_DF_W;
                    end
                end
                S_DF_W: begin
                    if (w_mul_done) begin
                        r_prev[r_ax] <= r_err;
                        if (r_dt == 16'd0) begin
                            // no time elapsed: derivative term drops out
                            r_rate      <= '0;
                            r_neg       <= r_eneg;
                            r_mul_a     <= MUL_AW'(mag64(64'(r_err)));
                            r_mul_b     <= r_kp;
                            r_mul_start <= 1'b1;
                            r_state     <= S_PM_W;
                        end else begin
                            r_div_n     <= w_prod + 64'(r_dt >> 1);
                            r_div_d     <= DIV_DW'(r_dt);
                            r_div_start <= 1'b1;
                            r_state     <= S_DD_W;
                        end
                    end
                end
                S_DD_W: begin
                    if (w_div_done) begin
                        r_rate      <= sat32(apply_sign(r_neg, w_quo));
                        r_neg       <= r_eneg;
                        r_mul_a     <= MUL_AW'(mag64(64'(r_err)));
                        r_mul_b     <= r_kp;
                        r_mul_start <= 1'b1;
                        r_state     <= S_PM_W;
                    end
                end
                S_PM_W: begin
                    if (w_mul_done) begin
                        r_u         <= apply_sign(r_neg, w_prnd);
                        r_neg       <= r_int[39];
                        r_mul_a     <= MUL_AW'(mag64(64'(r_int)));
                        r_mul_b     <= r_ki;
                        r_mul_start <= 1'b1;
                        r_state     <= S_IM_W;
                    end
                end
                S_IM_W: begin
                    if (w_mul_done) begin
                        r_div_n     <= w_prod + 64'(INT_HALF);
                        r_div_d     <= DIV_DW'(INT_DIV);
                        r_div_start <= 1'b1;
                        r_state     <= S_ID_W;
                    end
                end
                S_ID_W: begin
                    if (w_div_done) begin
                        r_u         <= r_u + apply_sign(r_neg, w_quo);
                        r_neg       <= r_rate[31];
                        r_mul_a     <= MUL_AW'(mag64(64'(r_rate)));
                        r_mul_b     <= r_kd;
                        r_mul_start <= 1'b1;
                        r_state     <= S_DM_W;
                    end
                end
                S_DM_W: begin
                    if (w_mul_done) begin
                        r_u     <= r_u + apply_sign(r_neg, w_prnd);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_axis  <= r_kind;
                        r_out_servo <= w_servo;
                        r_out_filt  <= sat16(r_est);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_axis;
    assign m_axis_tdata  = {r_out_filt, r_out_servo};

    `KPA_ASSERT_NXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accept did not leave idle")
    `KPA_ASSERT_IMP(a_servo_range, m_axis_tvalid, m_axis_tdata[7:0] <= 8'd180, "servo out of range")
    `KPA_ASSERT_IMP(a_out_load, $rose(m_axis_tvalid), $past(r_state == S_DONE), "result loaded outside done")
    `KPA_ASSERT_IMP(a_one_unit, r_mul_start, !r_div_start, "multiplier and divider started together")
endmodule
